[src/assert_macros.svh]
// Assertion macros shared by the loader RTL.
// Each macro checks a property on the rising edge of the given clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked property, switched off while the active-low reset is asserted.
`define IHEX_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked property that also holds during reset.
`define IHEX_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define IHEX_ASSERT(label, clk, rstn, prop, msg)
`define IHEX_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

[src/ihex_pkg.sv]
`timescale 1ns / 1ps

package ihex_pkg;

    // Width of the load address; one extra bit marks the end of memory.
    localparam int ADDR_BITS = 16;

    // Characters recognised in the text stream.
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Record type that carries the start address.
    localparam logic [7:0] REC_START = 8'h05;

    // Position in the record.
    typedef enum logic [2:0] {
        PH_COLON = 3'd0,
        PH_COUNT = 3'd1,
        PH_ADDR  = 3'd2,
        PH_TYPE  = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5
    } phase_t;

    // Result event codes.
    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_WRITE = 3'd1,
        EV_START = 3'd2,
        EV_DONE  = 3'd3,
        EV_ERROR = 3'd4
    } event_t;

    // Error codes.
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_COLON = 2'd1,
        ERR_DIGIT = 2'd2
    } err_t;

    // Parser state carried from one word to the next.
    typedef struct packed {
        phase_t               phase;
        logic [1:0]           digit_index;
        logic [15:0]          acc;
        logic [7:0]           bytes_left;
        logic [ADDR_BITS:0]   load_address;
        logic                 halted;
    } parse_state_t;

    // One result word.
    typedef struct packed {
        event_t                 evt;
        err_t                   err;
        logic [ADDR_BITS-1:0]   addr;
        logic [7:0]             data;
    } result_t;

    localparam parse_state_t PARSE_RESET = '{
        phase:        PH_COLON,
        digit_index:  2'd0,
        acc:          16'd0,
        bytes_left:   8'd0,
        load_address: '0,
        halted:       1'b0
    };

    localparam result_t RESULT_NONE = '{
        evt:  EV_NONE,
        err:  ERR_NONE,
        addr: '0,
        data: 8'd0
    };

    // Decodes one ASCII hex digit: bit 4 is set for a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

[src/intel_hex_record_loader.sv]
`timescale 1ns / 1ps
// Intel HEX record loader.
// The s_ channel takes one ASCII character per word on s_char_in; the m_
// channel gives exactly one result word per character: m_event_res,
// m_error_kind, m_addr and m_data. Both channels use valid and ready.
// A character is taken into an input register, decoded against the parser
// state in a single pass of logic and written into the result register,
// which holds it until the receiver takes it. A new character can be
// accepted on every cycle while results are taken.
// The input register and the result register are the only buffering: when
// the receiver holds m_ready low, the pending character waits in the input
// register and s_ready falls once both registers are full.
// A malformed stream reports one error word and then halts the parser: all
// later characters are taken and give empty result words until reset.
// The synchronous active-low reset empties both registers and returns the
// parser to waiting for a colon, with no clearing pass.
`include "assert_macros.svh"

module intel_hex_record_loader
    import ihex_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_char_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_event_res,
    output logic [1:0]           m_error_kind,
    output logic [ADDR_BITS-1:0] m_addr,
    output logic [7:0]           m_data
);

    logic         in_valid_reg;
    logic [7:0]   char_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         out_valid_reg;
    result_t      result_reg;
    result_t      result_next;
    logic         advance;

    // A buffered word moves on when the result register is free or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    ihex_parse u_parse (
        .cur     (state_reg),
        .char_in (char_reg),
        .nxt     (state_next),
        .res     (result_next)
    );

    // Control state and parser state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= PARSE_RESET;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg <= s_char_in;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_event_res  = result_reg.evt;
    assign m_error_kind = result_reg.err;
    assign m_addr       = result_reg.addr;
    assign m_data       = result_reg.data;

    // Once halted, the parser stays halted until reset.
    `IHEX_ASSERT(a_halt_sticky, aclk, aresetn, state_reg.halted |=> state_reg.halted, "halt lost")
    // An error word on the output implies the parser has halted.
    `IHEX_ASSERT(a_error_halts, aclk, aresetn, (out_valid_reg && result_reg.evt == EV_ERROR) |-> state_reg.halted, "error without halt")
    // The error code is set exactly on error words.
    `IHEX_ASSERT(a_err_code, aclk, aresetn, out_valid_reg |-> ((result_reg.evt == EV_ERROR) == (result_reg.err != ERR_NONE)), "error code mismatch")
    // The data phase is only entered with bytes still to come.
    `IHEX_ASSERT(a_data_count, aclk, aresetn, (state_reg.phase == PH_DATA) |-> (state_reg.bytes_left != 8'd0), "data phase with zero count")
    // A word that leaves the input register always lands in the result register.
    `IHEX_ASSERT_ALWAYS(a_advance_out, aclk, (aresetn && advance) |=> (!aresetn || out_valid_reg), "result word lost")

endmodule

[src/ihex_parse.sv]
`timescale 1ns / 1ps

module ihex_parse
    import ihex_pkg::*;
(
    input  parse_state_t cur,
    input  logic [7:0]   char_in,
    output parse_state_t nxt,
    output result_t      res
);

    logic [4:0]          hex;
    logic                is_hex;
    logic [15:0]         acc_shift;
    logic                field_last;
    logic [7:0]          bytes_dec;
    logic                addr_ok;
    logic                is_break;

    // Digit decode and the shared field arithmetic.
    assign hex        = hex_value(char_in);
    assign is_hex     = hex[4];
    assign acc_shift  = {cur.acc[11:0], hex[3:0]};
    assign field_last = (cur.phase == PH_ADDR) ? (cur.digit_index == 2'd3)
                                               : (cur.digit_index != 2'd0);
    assign bytes_dec  = cur.bytes_left - 8'd1;
    assign addr_ok    = !cur.load_address[ADDR_BITS];
    assign is_break   = (char_in == CH_CR) || (char_in == CH_LF);

    // Next state.
    always_comb begin
        nxt = cur;
        if (!cur.halted) begin
            case (cur.phase)
                PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_CHECK: begin
                    if (!is_hex) begin
                        nxt.halted = 1'b1;
                    end else if (!field_last) begin
                        nxt.acc         = acc_shift;
                        nxt.digit_index = cur.digit_index + 2'd1;
                    end else begin
                        // A field is complete: start the next one from zero.
                        nxt.acc         = 16'd0;
                        nxt.digit_index = 2'd0;
                        case (cur.phase)
                            PH_COUNT: begin
                                nxt.bytes_left = acc_shift[7:0];
                                nxt.phase      = PH_ADDR;
                            end
                            PH_ADDR: begin
                                nxt.load_address = {1'b0, acc_shift[ADDR_BITS-1:0]};
                                nxt.phase        = PH_TYPE;
                            end
                            PH_TYPE: begin
                                nxt.phase = (cur.bytes_left != 8'd0) ? PH_DATA : PH_CHECK;
                            end
                            PH_DATA: begin
                                if (addr_ok) begin
                                    nxt.load_address = cur.load_address + 1'b1;
                                end
                                nxt.bytes_left = bytes_dec;
                                nxt.phase      = (bytes_dec != 8'd0) ? PH_DATA : PH_CHECK;
                            end
                            default: begin
                                nxt.phase = PH_COLON;
                            end
                        endcase
                    end
                end
                default: begin
                    // Between records: skip line breaks, expect a colon.
                    if (char_in == CH_COLON) begin
                        nxt.phase       = PH_COUNT;
                        nxt.digit_index = 2'd0;
                        nxt.acc         = 16'd0;
                    end else if (!is_break) begin
                        nxt.halted = 1'b1;
                    end
                end
            endcase
        end
    end

    // Result word.
    always_comb begin
        res = RESULT_NONE;
        if (!cur.halted) begin
            case (cur.phase)
                PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_CHECK: begin
                    if (!is_hex) begin
                        res.evt = EV_ERROR;
                        res.err = ERR_DIGIT;
                    end else if (field_last) begin
                        case (cur.phase)
                            PH_TYPE: begin
                                if (acc_shift[7:0] == REC_START) begin
                                    res.evt  = EV_START;
                                    res.addr = cur.load_address[ADDR_BITS-1:0];
                                end
                            end
                            PH_DATA: begin
                                if (addr_ok) begin
                                    res.evt  = EV_WRITE;
                                    res.addr = cur.load_address[ADDR_BITS-1:0];
                                    res.data = acc_shift[7:0];
                                end
                            end
                            PH_CHECK: begin
                                res.evt = EV_DONE;
                            end
                            default: begin
                                res.evt = EV_NONE;
                            end
                        endcase
                    end
                end
                default: begin
                    if (char_in != CH_COLON && !is_break) begin
                        res.evt = EV_ERROR;
                        res.err = ERR_COLON;
                    end
                end
            endcase
        end
    end

endmodule

[tb/intel_hex_record_loader_tb.sv]
`timescale 1ns / 1ps

module intel_hex_record_loader_tb;
    import ihex_pkg::*;

    localparam int STIM_CHARS  = 2000;
    localparam int NOISE_CHARS = 200;
    localparam int STALL_LIMIT = 2000;
    localparam int SHOWN_FAILS = 10;

    // One result word as the parser should report it.
    typedef struct {
        event_t               ev;
        err_t                 err;
        logic [ADDR_BITS-1:0] addr;
        logic [7:0]           data;
    } loader_word_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_char_in;
    logic                 m_valid;
    logic                 m_ready;
    logic [2:0]           m_event_res;
    logic [1:0]           m_error_kind;
    logic [ADDR_BITS-1:0] m_addr;
    logic [7:0]           m_data;

    // Characters waiting to be offered, and the result words still to arrive.
    logic [7:0]   pending_chars[$];
    loader_word_t predicted_words[$];

    int   total_chars     = 0;
    int   chars_taken     = 0;
    int   fail_count      = 0;
    int   stall_cycles    = 0;
    int   sender_idle_pct = 7;
    int   recv_idle_pct   = 70;
    logic offer_pending   = 1'b0;

    // Parser state as predicted by the testbench.
    phase_t             rec_phase      = PH_COLON;
    logic [1:0]         rec_digits     = 2'd0;
    logic [15:0]        rec_field      = 16'd0;
    logic [7:0]         rec_bytes_left = 8'd0;
    logic [ADDR_BITS:0] rec_load_addr  = '0;
    logic               rec_halted     = 1'b0;

    intel_hex_record_loader dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_in    (s_char_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_res  (m_event_res),
        .m_error_kind (m_error_kind),
        .m_addr       (m_addr),
        .m_data       (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Value of an ASCII hex digit, or -1 for any other character.
    function automatic int digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return int'(c) - int'("0");
        end else if (c >= "A" && c <= "F") begin
            return int'(c) - int'("A") + 10;
        end else if (c >= "a" && c <= "f") begin
            return int'(c) - int'("a") + 10;
        end
        return -1;
    endfunction

    // ASCII digit for a nibble, letters in either case at random.
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return 8'h30 + 8'(v);
        end else if ($urandom_range(0, 1) == 0) begin
            return 8'h41 + 8'(v) - 8'd10;
        end
        return 8'h61 + 8'(v) - 8'd10;
    endfunction

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            pending_chars.push_back(s[i]);
        end
    endtask

    task automatic queue_byte(input logic [7:0] b);
        pending_chars.push_back(hex_char(b[7:4]));
        pending_chars.push_back(hex_char(b[3:0]));
    endtask

    // A complete record with random data bytes and a random checksum.
    task automatic queue_record(input int count, input logic [15:0] load, input logic [7:0] rtype);
        int sel;
        pending_chars.push_back(CH_COLON);
        queue_byte(8'(count));
        queue_byte(load[15:8]);
        queue_byte(load[7:0]);
        queue_byte(rtype);
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                queue_byte(8'h00);
            end else if (sel == 1) begin
                queue_byte(8'hFF);
            end else begin
                queue_byte(8'($urandom_range(0, 255)));
            end
        end
        queue_byte(8'($urandom_range(0, 255)));
    endtask

    // Advances the predicted parser by one character and records its result word.
    task automatic decode_char(input logic [7:0] c);
        loader_word_t w;
        int           dv;
        int           need;
        w = '{ev: EV_NONE, err: ERR_NONE, addr: '0, data: 8'd0};
        if (rec_halted) begin
            // Nothing more is reported until reset.
        end else if (rec_phase < PH_COUNT || rec_phase > PH_CHECK) begin
            if (c == CH_COLON) begin
                rec_phase  = PH_COUNT;
                rec_digits = 2'd0;
                rec_field  = 16'd0;
            end else if (c != CH_CR && c != CH_LF) begin
                rec_halted = 1'b1;
                w.ev       = EV_ERROR;
                w.err      = ERR_COLON;
            end
        end else begin
            dv = digit_of(c);
            if (dv < 0) begin
                rec_halted = 1'b1;
                w.ev       = EV_ERROR;
                w.err      = ERR_DIGIT;
            end else begin
                rec_field = {rec_field[11:0], 4'(dv)};
                need      = (rec_phase == PH_ADDR) ? 4 : 2;
                if (int'(rec_digits) + 1 < need) begin
                    rec_digits = rec_digits + 2'd1;
                end else begin
                    case (rec_phase)
                        PH_COUNT: begin
                            rec_bytes_left = rec_field[7:0];
                            rec_phase      = PH_ADDR;
                        end
                        PH_ADDR: begin
                            rec_load_addr = {1'b0, rec_field};
                            rec_phase     = PH_TYPE;
                        end
                        PH_TYPE: begin
                            if (rec_field[7:0] == REC_START) begin
                                w.ev   = EV_START;
                                w.addr = rec_load_addr[ADDR_BITS-1:0];
                            end
                            rec_phase = (rec_bytes_left != 8'd0) ? PH_DATA : PH_CHECK;
                        end
                        PH_DATA: begin
                            // Past the top of memory the byte is dropped.
                            if (!rec_load_addr[ADDR_BITS]) begin
                                w.ev          = EV_WRITE;
                                w.addr        = rec_load_addr[ADDR_BITS-1:0];
                                w.data        = rec_field[7:0];
                                rec_load_addr = rec_load_addr + 1'b1;
                            end
                            rec_bytes_left = rec_bytes_left - 8'd1;
                            rec_phase = (rec_bytes_left != 8'd0) ? PH_DATA : PH_CHECK;
                        end
                        default: begin
                            w.ev      = EV_DONE;
                            rec_phase = PH_COLON;
                        end
                    endcase
                    rec_digits = 2'd0;
                    rec_field  = 16'd0;
                end
            end
        end
        predicted_words.push_back(w);
    endtask

    // Sender: offers the next character at the falling edge and holds it until taken.
    always @(negedge aclk) begin : drive_chars
        logic       nv;
        logic [7:0] nc;
        nv = s_valid;
        nc = s_char_in;
        if (aresetn !== 1'b1) begin
            nv = 1'b0;
        end else if (!offer_pending) begin
            if (pending_chars.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                nc            = pending_chars.pop_front();
                nv            = 1'b1;
                offer_pending = 1'b1;
            end else begin
                nv = 1'b0;
            end
        end
        s_valid   <= nv;
        s_char_in <= nc;
    end

    // Receiver: takes result words or stalls at random.
    always @(negedge aclk) begin
        m_ready <= (aresetn === 1'b1) && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Checks each result word against the oldest prediction, then predicts for a new character.
    always @(posedge aclk) begin : check_words
        loader_word_t want;
        logic         took_char;
        logic         took_word;
        took_char = (aresetn === 1'b1) && (s_valid === 1'b1) && (s_ready === 1'b1);
        took_word = (aresetn === 1'b1) && (m_valid === 1'b1) && (m_ready === 1'b1);
        if (took_word) begin
            if (predicted_words.size() == 0) begin
                fail_count++;
                if (fail_count <= SHOWN_FAILS) begin
                    $display("%0t: unexpected word event %0d error %0d addr %h data %h",
                             $realtime, m_event_res, m_error_kind, m_addr, m_data);
                end
            end else begin
                want = predicted_words.pop_front();
                if (m_event_res !== want.ev || m_error_kind !== want.err ||
                    m_addr !== want.addr || m_data !== want.data) begin
                    fail_count++;
                    if (fail_count <= SHOWN_FAILS) begin
                        $display("%0t: expected event %0d error %0d addr %h data %h",
                                 $realtime, want.ev, want.err, want.addr, want.data);
                        $display("%0t:   actual event %0d error %0d addr %h data %h",
                                 $realtime, m_event_res, m_error_kind, m_addr, m_data);
                    end
                end
            end
        end
        if (took_char) begin
            decode_char(s_char_in);
            offer_pending = 1'b0;
            chars_taken++;
            // The receiver stalls most in the first third, the sender in the second.
            if (chars_taken < total_chars / 3) begin
                sender_idle_pct = 7;
                recv_idle_pct   = 70;
            end else if (chars_taken < (2 * total_chars) / 3) begin
                sender_idle_pct = 70;
                recv_idle_pct   = 7;
            end else begin
                sender_idle_pct = 0;
                recv_idle_pct   = 0;
            end
        end
        if (took_char || took_word) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
    end

    // Watchdog on cycles with no word moving on either channel.
    always @(posedge aclk) begin
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, stall_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int         sel;
        int         count;
        int         k;
        logic [15:0] load;
        logic [7:0] rtype;
        logic [7:0] c;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_char_in = 8'h00;
        m_ready   = 1'b0;

        // Directed: line breaks, a start record with no data and mixed-case digits,
        // then a write at the top of memory whose second byte falls off the end.
        pending_chars.push_back(CH_CR);
        pending_chars.push_back(CH_LF);
        queue_text(":00abCD05Ff");
        queue_text(":02FFFF0009fAcE");

        // Random well-formed records, mostly short, a few of any length up to 255 bytes.
        while (pending_chars.size() < STIM_CHARS) begin
            repeat ($urandom_range(0, 2)) begin
                pending_chars.push_back(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
            end
            sel = $urandom_range(0, 99);
            if (sel < 3) begin
                count = $urandom_range(0, 255);
            end else if (sel < 15) begin
                count = 0;
            end else begin
                count = $urandom_range(1, 8);
            end
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
                load = 16'($urandom_range(16'hFFF0, 16'hFFFF));
            end else if (sel < 25) begin
                load = 16'h0000;
            end else begin
                load = 16'($urandom_range(0, 16'hFFFF));
            end
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                rtype = REC_START;
            end else if (sel < 80) begin
                rtype = 8'($urandom_range(0, 5));
            end else begin
                rtype = 8'($urandom_range(0, 255));
            end
            queue_record(count, load, rtype);
        end

        // Close with one malformed character: a bad leading character, or a non-digit
        // after a colon and up to 14 random digits, line breaks included.
        if ($urandom_range(0, 1) == 0) begin
            do begin
                c = 8'($urandom_range(0, 255));
            end while (c == CH_COLON || c == CH_CR || c == CH_LF);
            pending_chars.push_back(c);
        end else begin
            pending_chars.push_back(CH_COLON);
            k = $urandom_range(0, 14);
            repeat (k) pending_chars.push_back(hex_char(4'($urandom_range(0, 15))));
            if ($urandom_range(0, 2) == 0) begin
                c = ($urandom_range(0, 1) == 0) ? CH_CR : CH_LF;
            end else begin
                do begin
                    c = 8'($urandom_range(0, 255));
                end while (digit_of(c) >= 0);
            end
            pending_chars.push_back(c);
        end

        // The halted parser must ignore anything that follows.
        repeat (NOISE_CHARS) pending_chars.push_back(8'($urandom_range(0, 255)));
        total_chars = pending_chars.size();

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_chars.size() != 0 || offer_pending || predicted_words.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);

        if (predicted_words.size() != 0) begin
            $display("%0d result words never arrived", predicted_words.size());
            fail_count += predicted_words.size();
        end
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
